[sv/m4inv_pkg.sv]
`default_nettype none
package m4inv_pkg;
    localparam int ACC_W          = 64;
    localparam int HALF_W         = ACC_W / 2;
    localparam int WORD_BITS_DEF  = 32;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    // result of a saturating op: value plus clip flag
    typedef struct packed {
        logic                    clip;
        logic signed [ACC_W-1:0] val;
    } sat_res_t;

    function automatic sat_res_t sat_add(input logic signed [ACC_W-1:0] a,
                                         input logic signed [ACC_W-1:0] b);
        logic signed [ACC_W:0] sum;
        sat_res_t r;
        sum = {a[ACC_W-1], a} + {b[ACC_W-1], b};
        r.clip = (sum[ACC_W] != sum[ACC_W-1]);
        r.val  = r.clip ? (sum[ACC_W] ? ACC_MIN : ACC_MAX) : sum[ACC_W-1:0];
        return r;
    endfunction

    function automatic sat_res_t sat_neg(input logic signed [ACC_W-1:0] a);
        sat_res_t r;
        r.clip = (a == ACC_MIN);
        r.val  = r.clip ? ACC_MAX : -a;
        return r;
    endfunction

    // a - b as add(a, neg(b)), clips ORed
    function automatic sat_res_t sat_sub(input logic signed [ACC_W-1:0] a,
                                         input logic signed [ACC_W-1:0] b);
        sat_res_t n;
        sat_res_t r;
        n = sat_neg(b);
        r = sat_add(a, n.val);
        r.clip = r.clip | n.clip;
        return r;
    endfunction

    function automatic logic [ACC_W-1:0] mag64(input logic signed [ACC_W-1:0] a);
        return a[ACC_W-1] ? (~a + 1'b1) : a;
    endfunction
endpackage
`default_nettype wire

[sv/m4inv_mul.sv]
`default_nettype none
// 64x64 signed fixed-point multiply: four 32x32 partial products, then
// shift by FRAC_BITS (floor) and saturate to 64 bits.
module m4inv_mul
    import m4inv_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    start,
    input  wire logic signed [ACC_W-1:0] op_a,
    input  wire logic signed [ACC_W-1:0] op_b,
    output logic                         done,
    output logic signed [ACC_W-1:0]      res,
    output logic                         clip
);
    localparam int PW = 2 * ACC_W;

    logic [ACC_W-1:0]  a_reg, b_reg;
    logic              sgn_reg;
    logic [PW-1:0]     acc_reg;
    logic [ACC_W-1:0]  pp_reg;
    logic [1:0]        sh_reg;
    logic [2:0]        cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic signed [ACC_W-1:0] res_reg;
    logic              clip_reg;

    logic [HALF_W-1:0] x_op, y_op;
    logic [1:0]        sh_next;
    logic [PW-1:0]     signed_prod;
    logic signed [PW-1:0] shifted;
    logic              fits;

    always_comb begin
        unique case (cnt_reg[1:0])
            2'd0: begin x_op = a_reg[HALF_W-1:0];     y_op = b_reg[HALF_W-1:0];     sh_next = 2'd0; end
            2'd1: begin x_op = a_reg[HALF_W-1:0];     y_op = b_reg[ACC_W-1:HALF_W]; sh_next = 2'd1; end
            2'd2: begin x_op = a_reg[ACC_W-1:HALF_W]; y_op = b_reg[HALF_W-1:0];     sh_next = 2'd1; end
            default: begin x_op = a_reg[ACC_W-1:HALF_W]; y_op = b_reg[ACC_W-1:HALF_W]; sh_next = 2'd2; end
        endcase
    end

    assign signed_prod = sgn_reg ? (~acc_reg + 1'b1) : acc_reg;
    assign shifted     = $signed(signed_prod) >>> FRAC_BITS;
    assign fits        = (&shifted[PW-1:ACC_W-1]) | ~(|shifted[PW-1:ACC_W-1]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 3'd1;
                if (cnt_reg == 3'd5) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            a_reg   <= mag64(op_a);
            b_reg   <= mag64(op_b);
            sgn_reg <= op_a[ACC_W-1] ^ op_b[ACC_W-1];
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (cnt_reg < 3'd4) begin
                pp_reg <= ACC_W'(x_op) * ACC_W'(y_op);
                sh_reg <= sh_next;
            end
            if (cnt_reg >= 3'd1 && cnt_reg <= 3'd4)
                acc_reg <= acc_reg + ({{ACC_W{1'b0}}, pp_reg} << (HALF_W * sh_reg));
            if (cnt_reg == 3'd5) begin
                clip_reg <= ~fits;
                res_reg  <= fits ? shifted[ACC_W-1:0] :
                            (shifted[PW-1] ? ACC_MIN : ACC_MAX);
            end
        end
    end

    assign done = done_reg;
    assign res  = res_reg;
    assign clip = clip_reg;
endmodule
`default_nettype wire

[sv/m4inv_div.sv]
`default_nettype none
// Restoring divider, one quotient bit per cycle: q = (num << FRAC_BITS) / den
module m4inv_div
    import m4inv_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             start,
    input  wire logic [ACC_W-1:0] num,
    input  wire logic [ACC_W-1:0] den,
    output logic                  done,
    output logic [ACC_W+FRAC_BITS-1:0] quo
);
    localparam int DIVW = ACC_W + FRAC_BITS;
    localparam int CW   = $clog2(DIVW + 1);

    logic [DIVW-1:0]  dvd_reg, q_reg;
    logic [ACC_W-1:0] rem_reg, den_reg;
    logic [CW-1:0]    cnt_reg;
    logic             busy_reg, done_reg;
    logic [ACC_W:0]   rem_s;
    logic             ge;

    assign rem_s = {rem_reg, dvd_reg[DIVW-1]};
    assign ge    = (rem_s >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(DIVW - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dvd_reg <= {num, {FRAC_BITS{1'b0}}};
            den_reg <= den;
            rem_reg <= '0;
            q_reg   <= '0;
        end else if (busy_reg) begin
            dvd_reg <= {dvd_reg[DIVW-2:0], 1'b0};
            rem_reg <= ge ? ACC_W'(rem_s - {1'b0, den_reg}) : rem_s[ACC_W-1:0];
            q_reg   <= {q_reg[DIVW-2:0], ge};
        end
    end

    assign done = done_reg;
    assign quo  = q_reg;
endmodule
`default_nettype wire

[sv/matrix4_inverse_unit.sv]
// 4x4 matrix inverse by adjugate, signed fixed point (Q16.16 by default).
// Sixteen elements load row-major, one beat per cycle. The block then drops
// s_ready and forms the adjugate and determinant on one shared 64x64
// multiplier (four 32x32 partial products, 9 products per 3x3 minor plus
// fetch/store), then divides each adjugate entry by the determinant on a
// bit-serial divider (no division when singular). Results leave row-major
// with last_element on the sixteenth beat, each beat held until m_ready.
// Zero determinant gives zeros flagged singular; clipped intermediates or
// outputs set saturated.
`default_nettype none
module matrix4_inverse_unit
    import m4inv_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_valid,
    output logic                      s_ready,
    input  wire logic [WORD_BITS-1:0] s_element_value,
    output logic                      m_valid,
    input  wire logic                 m_ready,
    output logic [WORD_BITS-1:0]      m_inverse_value,
    output logic                      m_last_element,
    output logic                      m_singular,
    output logic                      m_saturated
);
    localparam int DIVW = ACC_W + FRAC_BITS;

    localparam logic [3:0] ST_LOAD     = 4'd0;
    localparam logic [3:0] ST_ADJ_RD   = 4'd1;
    localparam logic [3:0] ST_ADJ_MUL  = 4'd2;
    localparam logic [3:0] ST_ADJ_WAIT = 4'd3;
    localparam logic [3:0] ST_ADJ_ST   = 4'd4;
    localparam logic [3:0] ST_DET_RD   = 4'd5;
    localparam logic [3:0] ST_DET_MUL  = 4'd6;
    localparam logic [3:0] ST_DET_WAIT = 4'd7;
    localparam logic [3:0] ST_OUT_RD   = 4'd8;
    localparam logic [3:0] ST_OUT_DIV  = 4'd9;
    localparam logic [3:0] ST_OUT_WAIT = 4'd10;
    localparam logic [3:0] ST_OUT_SEND = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] cnt_reg;    // load index, adjugate entry, det term or output index
    logic [3:0] step_reg;

    logic [WORD_BITS-1:0]    mat_mem [16];
    logic [WORD_BITS-1:0]    mat_rd_a_reg, mat_rd_b_reg;
    logic signed [ACC_W-1:0] adj_mem [16];
    logic signed [ACC_W-1:0] adj_rd_reg;
    logic [15:0]             adj_clip_reg;

    logic signed [ACC_W-1:0] p_reg, t_reg, s_reg, det_reg;
    logic                    clip_reg, det_clip_reg, neg_reg;

    logic [WORD_BITS-1:0]    out_val_reg;
    logic                    out_last_reg, out_sing_reg, out_sat_reg, m_valid_reg;

    // operand positions inside the 3x3 minor
    logic [1:0] ai, aj, bi, bj;
    logic       b_is_t;
    logic [3:0] addr_a, addr_b, adj_addr;
    logic [1:0] ex_row, ex_col;

    logic signed [ACC_W-1:0] mul_a, mul_b, mul_res;
    logic                    mul_start, mul_done, mul_clip;
    logic                    div_start, div_done;
    logic [DIVW-1:0]         div_q;
    logic signed [ACC_W-1:0] mat_a_ext, mat_b_ext;

    sat_res_t sub_pr, sub_sr, add_sr, neg_s, add_det;

    logic [WORD_BITS-1:0] limit;
    logic                 q_over;
    logic [WORD_BITS-1:0] q_w;

    always_comb begin
        b_is_t = 1'b0;
        unique case (step_reg)
            4'd0: begin ai = 2'd1; aj = 2'd1; bi = 2'd2; bj = 2'd2; end
            4'd1: begin ai = 2'd1; aj = 2'd2; bi = 2'd2; bj = 2'd1; end
            4'd2: begin ai = 2'd0; aj = 2'd0; bi = 2'd0; bj = 2'd0; b_is_t = 1'b1; end
            4'd3: begin ai = 2'd1; aj = 2'd0; bi = 2'd2; bj = 2'd2; end
            4'd4: begin ai = 2'd1; aj = 2'd2; bi = 2'd2; bj = 2'd0; end
            4'd5: begin ai = 2'd0; aj = 2'd1; bi = 2'd0; bj = 2'd0; b_is_t = 1'b1; end
            4'd6: begin ai = 2'd1; aj = 2'd0; bi = 2'd2; bj = 2'd1; end
            4'd7: begin ai = 2'd1; aj = 2'd1; bi = 2'd2; bj = 2'd0; end
            default: begin ai = 2'd0; aj = 2'd2; bi = 2'd0; bj = 2'd0; b_is_t = 1'b1; end
        endcase
    end

    // adjugate[r][c] uses the minor without row c and column r
    assign ex_row = cnt_reg[1:0];
    assign ex_col = cnt_reg[3:2];

    always_comb begin
        addr_a   = {(ai < ex_row) ? ai : ai + 2'd1, (aj < ex_col) ? aj : aj + 2'd1};
        addr_b   = {(bi < ex_row) ? bi : bi + 2'd1, (bj < ex_col) ? bj : bj + 2'd1};
        adj_addr = cnt_reg;
        if (state_reg == ST_LOAD) begin
            addr_a = cnt_reg;
        end else if (state_reg == ST_DET_RD) begin
            addr_a   = {2'd0, cnt_reg[1:0]};
            adj_addr = {cnt_reg[1:0], 2'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_LOAD && s_valid)
            mat_mem[cnt_reg] <= s_element_value;
        mat_rd_a_reg <= mat_mem[addr_a];
        mat_rd_b_reg <= mat_mem[addr_b];
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_ADJ_ST)
            adj_mem[cnt_reg] <= neg_s.val;
        adj_rd_reg <= adj_mem[adj_addr];
    end

    assign mat_a_ext = {{(ACC_W-WORD_BITS){mat_rd_a_reg[WORD_BITS-1]}}, mat_rd_a_reg};
    assign mat_b_ext = {{(ACC_W-WORD_BITS){mat_rd_b_reg[WORD_BITS-1]}}, mat_rd_b_reg};

    assign mul_start = (state_reg == ST_ADJ_MUL) || (state_reg == ST_DET_MUL);
    assign mul_a     = mat_a_ext;
    assign mul_b     = (state_reg == ST_DET_MUL) ? adj_rd_reg : (b_is_t ? t_reg : mat_b_ext);

    m4inv_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .done    (mul_done),
        .res     (mul_res),
        .clip    (mul_clip)
    );

    assign div_start = (state_reg == ST_OUT_DIV) && (det_reg != '0);

    m4inv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (mag64(adj_rd_reg)),
        .den     (mag64(det_reg)),
        .done    (div_done),
        .quo     (div_q)
    );

    assign sub_pr  = sat_sub(p_reg, mul_res);
    assign sub_sr  = sat_sub(s_reg, mul_res);
    assign add_sr  = sat_add(s_reg, mul_res);
    assign add_det = sat_add(det_reg, mul_res);
    // odd (r+c) negates the minor
    assign neg_s   = (cnt_reg[0] ^ cnt_reg[2]) ? sat_neg(s_reg)
                                               : sat_res_t'{clip: 1'b0, val: s_reg};

    assign limit  = neg_reg ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
    assign q_over = (div_q > DIVW'(limit));
    assign q_w    = q_over ? limit : div_q[WORD_BITS-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            cnt_reg     <= '0;
            step_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_LOAD: begin
                    if (s_valid) begin
                        cnt_reg <= cnt_reg + 4'd1;
                        if (cnt_reg == 4'd15) begin
                            step_reg  <= '0;
                            clip_reg  <= 1'b0;
                            state_reg <= ST_ADJ_RD;
                        end
                    end
                end
                ST_ADJ_RD:  state_reg <= ST_ADJ_MUL;
                ST_ADJ_MUL: state_reg <= ST_ADJ_WAIT;
                ST_ADJ_WAIT: begin
                    if (mul_done) begin
                        unique case (step_reg)
                            4'd1, 4'd4, 4'd7: begin
                                t_reg    <= sub_pr.val;
                                clip_reg <= clip_reg | mul_clip | sub_pr.clip;
                            end
                            4'd2: begin
                                s_reg    <= mul_res;
                                clip_reg <= clip_reg | mul_clip;
                            end
                            4'd5: begin
                                s_reg    <= sub_sr.val;
                                clip_reg <= clip_reg | mul_clip | sub_sr.clip;
                            end
                            4'd8: begin
                                s_reg    <= add_sr.val;
                                clip_reg <= clip_reg | mul_clip | add_sr.clip;
                            end
                            default: begin
                                p_reg    <= mul_res;
                                clip_reg <= clip_reg | mul_clip;
                            end
                        endcase
                        if (step_reg == 4'd8) begin
                            state_reg <= ST_ADJ_ST;
                        end else begin
                            step_reg  <= step_reg + 4'd1;
                            state_reg <= ST_ADJ_RD;
                        end
                    end
                end
                ST_ADJ_ST: begin
                    adj_clip_reg[cnt_reg] <= clip_reg | neg_s.clip;
                    cnt_reg  <= cnt_reg + 4'd1;
                    step_reg <= '0;
                    clip_reg <= 1'b0;
                    if (cnt_reg == 4'd15) begin
                        det_reg      <= '0;
                        det_clip_reg <= 1'b0;
                        state_reg    <= ST_DET_RD;
                    end else begin
                        state_reg <= ST_ADJ_RD;
                    end
                end
                ST_DET_RD:  state_reg <= ST_DET_MUL;
                ST_DET_MUL: state_reg <= ST_DET_WAIT;
                ST_DET_WAIT: begin
                    if (mul_done) begin
                        det_reg      <= add_det.val;
                        det_clip_reg <= det_clip_reg | mul_clip | add_det.clip;
                        if (cnt_reg == 4'd3) begin
                            cnt_reg   <= '0;
                            state_reg <= ST_OUT_RD;
                        end else begin
                            cnt_reg   <= cnt_reg + 4'd1;
                            state_reg <= ST_DET_RD;
                        end
                    end
                end
                ST_OUT_RD: state_reg <= ST_OUT_DIV;
                ST_OUT_DIV: begin
                    neg_reg      <= adj_rd_reg[ACC_W-1] ^ det_reg[ACC_W-1];
                    out_last_reg <= (cnt_reg == 4'd15);
                    if (det_reg == '0) begin
                        out_val_reg  <= '0;
                        out_sing_reg <= 1'b1;
                        out_sat_reg  <= 1'b0;
                        m_valid_reg  <= 1'b1;
                        state_reg    <= ST_OUT_SEND;
                    end else begin
                        state_reg <= ST_OUT_WAIT;
                    end
                end
                ST_OUT_WAIT: begin
                    if (div_done) begin
                        out_val_reg  <= neg_reg ? (~q_w + 1'b1) : q_w;
                        out_sing_reg <= 1'b0;
                        out_sat_reg  <= q_over | det_clip_reg | adj_clip_reg[cnt_reg];
                        m_valid_reg  <= 1'b1;
                        state_reg    <= ST_OUT_SEND;
                    end
                end
                ST_OUT_SEND: begin
                    if (m_ready) begin
                        m_valid_reg <= 1'b0;
                        cnt_reg     <= cnt_reg + 4'd1;
                        state_reg   <= (cnt_reg == 4'd15) ? ST_LOAD : ST_OUT_RD;
                    end
                end
                default: state_reg <= ST_LOAD;
            endcase
        end
    end

    assign s_ready         = (state_reg == ST_LOAD);
    assign m_valid         = m_valid_reg;
    assign m_inverse_value = out_val_reg;
    assign m_last_element  = out_last_reg;
    assign m_singular      = out_sing_reg;
    assign m_saturated     = out_sat_reg;
endmodule
`default_nettype wire

[sv/m4inv_checker.sv]
`default_nettype none
module m4inv_checker
    import m4inv_pkg::*;
#(
    parameter int WORD_BITS = WORD_BITS_DEF
) (
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_valid,
    input wire logic                 s_ready,
    input wire logic [WORD_BITS-1:0] s_element_value,
    input wire logic                 m_valid,
    input wire logic                 m_ready,
    input wire logic [WORD_BITS-1:0] m_inverse_value,
    input wire logic                 m_last_element,
    input wire logic                 m_singular,
    input wire logic                 m_saturated
);
    // loading and result delivery never overlap
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input ready while a result beat is pending");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_inverse_value))
        else $error("result beat dropped or changed while stalled");

    a_singular_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_singular |-> m_inverse_value == '0 && !m_saturated)
        else $error("singular beat with nonzero value or saturation");

    a_reload: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last_element |=> s_ready)
        else $error("not ready for the next matrix after last beat");

    a_input_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_element_value))
        else $error("input beat dropped or changed while stalled");
endmodule

bind matrix4_inverse_unit m4inv_checker #(.WORD_BITS(WORD_BITS)) u_m4inv_checker (.*);
`default_nettype wire
